// ----- rtl/rcyl_pkg.sv -----
package rcyl_pkg;

  // Port and field widths.
  localparam int IN_W     = 32;
  localparam int RAD_W    = 31;
  localparam int DIST_W   = 31;

  // Widths of the quadratic terms.
  localparam int D_W      = 33;   // origin minus centre
  localparam int H_W      = 65;   // half linear coefficient, signed
  localparam int HM_W     = 64;   // magnitude of h
  localparam int C_W      = 66;   // constant coefficient, signed
  localparam int CM_W     = 65;   // magnitude of c
  localparam int A_W      = 64;   // quadratic coefficient, unsigned
  localparam int RR_W     = 62;   // radius squared
  localparam int HALF_W   = 32;   // operand slice of the partial products
  localparam int PP_W     = 64;   // one partial product
  localparam int SQ_W     = 128;  // h*h and |a*c|
  localparam int DISC_W   = 130;  // discriminant, signed

  // Square root and root forming.
  localparam int ROOT_W   = 65;
  localparam int REM_W    = ROOT_W + 3;
  localparam int N_W      = 67;   // -h +/- s, signed
  localparam int SCALE_SH = 16;   // Q16.16 scaling of the numerator
  localparam int M_W      = 82;   // |numerator| << 16
  localparam int Q_W      = 40;   // quotient bits kept below the clamp
  localparam int T_W      = 42;   // signed root in Q16.16
  localparam int LANES    = 2;    // both roots side by side

  // Root selection limits, Q16.16.
  localparam int EPS_LO   = 66;   // 0.001
  localparam int T_MIN    = 6554; // 0.1

  // Values that ride along with the discriminant through the root unit.
  typedef struct packed {
    logic                     nohit;
    logic signed [H_W-1:0]    h;
    logic [A_W-1:0]           a;
    logic [DIST_W-1:0]        best;
  } rcyl_side_t;

  // Values that ride along with the numerators through the divider.
  typedef struct packed {
    logic                     nohit;
    logic [DIST_W-1:0]        best;
  } rcyl_tag_t;

endpackage

// ----- rtl/rcyl_quad.sv -----
module rcyl_quad (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [rcyl_pkg::IN_W-1:0]    origin_x,
  input  logic signed [rcyl_pkg::IN_W-1:0]    origin_z,
  input  logic signed [rcyl_pkg::IN_W-1:0]    direction_x,
  input  logic signed [rcyl_pkg::IN_W-1:0]    direction_z,
  input  logic signed [rcyl_pkg::IN_W-1:0]    centre_x,
  input  logic signed [rcyl_pkg::IN_W-1:0]    centre_z,
  input  logic [rcyl_pkg::RAD_W-1:0]          radius,
  input  logic [rcyl_pkg::DIST_W-1:0]         best_distance,
  output logic                                out_valid,
  output logic [rcyl_pkg::DISC_W-1:0]         disc,
  output rcyl_pkg::rcyl_side_t                out_side
);

  localparam int IN_W   = rcyl_pkg::IN_W;
  localparam int D_W    = rcyl_pkg::D_W;
  localparam int H_W    = rcyl_pkg::H_W;
  localparam int HM_W   = rcyl_pkg::HM_W;
  localparam int C_W    = rcyl_pkg::C_W;
  localparam int CM_W   = rcyl_pkg::CM_W;
  localparam int A_W    = rcyl_pkg::A_W;
  localparam int RR_W   = rcyl_pkg::RR_W;
  localparam int HALF_W = rcyl_pkg::HALF_W;
  localparam int PP_W   = rcyl_pkg::PP_W;
  localparam int SQ_W   = rcyl_pkg::SQ_W;
  localparam int DISC_W = rcyl_pkg::DISC_W;
  localparam int DIST_W = rcyl_pkg::DIST_W;

  // Stage valid bits.
  logic v_a, v_b, v_c, v_d, v_e, v_f, v_g;

  // Stage A: offsets from the axis.
  logic signed [D_W-1:0]  dx, dz;
  logic signed [IN_W-1:0] vx, vz;
  logic [rcyl_pkg::RAD_W-1:0] rad_a;
  logic [DIST_W-1:0]      best_a, best_b;

  // Stage B: first products.
  logic signed [H_W-1:0]  pdv_x, pdv_z;
  logic signed [C_W-1:0]  pdd_x, pdd_z;
  logic signed [A_W-1:0]  pvv_x, pvv_z;
  logic [RR_W-1:0]        rr;

  // Stage C onward.
  logic [A_W-1:0]         a_sum;
  logic signed [C_W-1:0]  c;
  rcyl_pkg::rcyl_side_t   side_c, side_d, side_e, side_f, side_g;
  logic [HM_W-1:0]        hm;
  logic [CM_W-1:0]        cm;
  logic                   cneg_d, cneg_e, cneg_f, cneg_g;
  logic [PP_W-1:0]        hp00, hp01, hp11;
  logic [PP_W-1:0]        ap00, ap01, ap10, ap11;
  logic [A_W-1:0]         ac2;
  logic [SQ_W-1:0]        hh_f, hh_g, ac_lo, ac_hi, acm;
  logic [DISC_W-1:0]      disc_next;

  assign a_sum = pvv_x + pvv_z;

  // Valid pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
      v_f <= 1'b0;
      v_g <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v_a <= in_valid;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
      v_e <= v_d;
      v_f <= v_e;
      v_g <= v_f;
      out_valid <= v_g;
    end
  end

  // Stages A to C: offsets, products of up to 33 by 33 bits, then the coefficients.
  always_ff @(posedge clk) begin
    dx     <= {origin_x[IN_W-1], origin_x} - {centre_x[IN_W-1], centre_x};
    dz     <= {origin_z[IN_W-1], origin_z} - {centre_z[IN_W-1], centre_z};
    vx     <= direction_x;
    vz     <= direction_z;
    rad_a  <= radius;
    best_a <= best_distance;

    pdv_x  <= dx * vx;
    pdv_z  <= dz * vz;
    pdd_x  <= dx * dx;
    pdd_z  <= dz * dz;
    pvv_x  <= vx * vx;
    pvv_z  <= vz * vz;
    rr     <= rad_a * rad_a;
    best_b <= best_a;

    side_c.h     <= pdv_x + pdv_z;
    side_c.a     <= a_sum;
    side_c.best  <= best_b;
    side_c.nohit <= (a_sum == '0);
    c            <= pdd_x + pdd_z - $signed({{(C_W-RR_W){1'b0}}, rr});
  end

  // Stage D: magnitudes, so the wide squares become unsigned slices.
  always_ff @(posedge clk) begin
    hm     <= side_c.h[H_W-1] ? HM_W'(-side_c.h) : HM_W'(side_c.h);
    cm     <= c[C_W-1] ? CM_W'(-c) : CM_W'(c);
    cneg_d <= c[C_W-1];
    side_d <= side_c;
  end

  // Stage E: 32 by 32 partial products of h*h and a*|c|.
  always_ff @(posedge clk) begin
    hp00   <= hm[HALF_W-1:0] * hm[HALF_W-1:0];
    hp01   <= hm[HALF_W-1:0] * hm[HM_W-1:HALF_W];
    hp11   <= hm[HM_W-1:HALF_W] * hm[HM_W-1:HALF_W];
    ap00   <= side_d.a[HALF_W-1:0] * cm[HALF_W-1:0];
    ap01   <= side_d.a[HALF_W-1:0] * cm[2*HALF_W-1:HALF_W];
    ap10   <= side_d.a[A_W-1:HALF_W] * cm[HALF_W-1:0];
    ap11   <= side_d.a[A_W-1:HALF_W] * cm[2*HALF_W-1:HALF_W];
    ac2    <= cm[CM_W-1] ? side_d.a : '0;
    cneg_e <= cneg_d;
    side_e <= side_d;
  end

  // Stages F and G: sum the partial products.
  always_ff @(posedge clk) begin
    hh_f   <= {hp11, hp00} + SQ_W'({hp01, {(HALF_W+1){1'b0}}});
    ac_lo  <= {ap11, ap00} + SQ_W'({ap01, {HALF_W{1'b0}}});
    ac_hi  <= SQ_W'({ac2, {PP_W{1'b0}}}) + SQ_W'({ap10, {HALF_W{1'b0}}});
    cneg_f <= cneg_e;
    side_f <= side_e;

    acm    <= ac_lo + ac_hi;
    hh_g   <= hh_f;
    cneg_g <= cneg_f;
    side_g <= side_f;
  end

  // Stage H: discriminant h*h - a*c; a negative one is a miss.
  always_comb begin
    if (cneg_g) begin
      disc_next = {2'b00, hh_g} + {2'b00, acm};
    end else begin
      disc_next = {2'b00, hh_g} - {2'b00, acm};
    end
  end

  always_ff @(posedge clk) begin
    disc           <= disc_next;
    out_side.h     <= side_g.h;
    out_side.a     <= side_g.a;
    out_side.best  <= side_g.best;
    out_side.nohit <= side_g.nohit | disc_next[DISC_W-1];
  end

endmodule

// ----- rtl/rcyl_sqrt.sv -----
module rcyl_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [rcyl_pkg::DISC_W-1:0]   disc,
  input  rcyl_pkg::rcyl_side_t          in_side,
  output logic                          out_valid,
  output logic [rcyl_pkg::ROOT_W-1:0]   root,
  output rcyl_pkg::rcyl_side_t          out_side
);

  localparam int DISC_W = rcyl_pkg::DISC_W;
  localparam int ROOT_W = rcyl_pkg::ROOT_W;
  localparam int REM_W  = rcyl_pkg::REM_W;

  // One stage per root bit; each stage brings in two radicand bits.
  logic                 vld_s  [1:ROOT_W];
  logic [DISC_W-1:0]    xs     [1:ROOT_W];
  logic [REM_W-1:0]     rem_s  [1:ROOT_W];
  logic [ROOT_W-1:0]    root_s [1:ROOT_W];
  rcyl_pkg::rcyl_side_t side_s [1:ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic                 vin;
    logic [DISC_W-1:0]    xin;
    logic [REM_W-1:0]     rin;
    logic [ROOT_W-1:0]    qin;
    rcyl_pkg::rcyl_side_t sin;
    logic [REM_W-1:0]     rsh, trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign xin = disc;
      assign rin = '0;
      assign qin = '0;
      assign sin = in_side;
    end else begin : g_next
      assign vin = vld_s[k];
      assign xin = xs[k];
      assign rin = rem_s[k];
      assign qin = root_s[k];
      assign sin = side_s[k];
    end

    // Trial subtract of 4*root + 1 from the shifted remainder.
    assign rsh   = {rin[REM_W-3:0], xin[DISC_W-1 -: 2]};
    assign trial = REM_W'({qin, 2'b01});
    assign ge    = (rsh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      xs[k+1]     <= {xin[DISC_W-3:0], 2'b00};
      rem_s[k+1]  <= ge ? (rsh - trial) : rsh;
      root_s[k+1] <= {qin[ROOT_W-2:0], ge};
      side_s[k+1] <= sin;
    end
  end

  assign out_valid = vld_s[ROOT_W];
  assign root      = root_s[ROOT_W];
  assign out_side  = side_s[ROOT_W];

endmodule

// ----- rtl/rcyl_div.sv -----
module rcyl_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [rcyl_pkg::M_W-1:0]      num [rcyl_pkg::LANES],
  input  logic                          num_neg [rcyl_pkg::LANES],
  input  logic [rcyl_pkg::A_W-1:0]      divisor,
  input  rcyl_pkg::rcyl_tag_t           in_tag,
  output logic                          out_valid,
  output logic [rcyl_pkg::Q_W-1:0]      quot [rcyl_pkg::LANES],
  output logic                          sat [rcyl_pkg::LANES],
  output logic                          rem_nz [rcyl_pkg::LANES],
  output logic                          out_neg [rcyl_pkg::LANES],
  output rcyl_pkg::rcyl_tag_t           out_tag
);

  localparam int M_W   = rcyl_pkg::M_W;
  localparam int A_W   = rcyl_pkg::A_W;
  localparam int Q_W   = rcyl_pkg::Q_W;
  localparam int LANES = rcyl_pkg::LANES;

  // Restoring division, one numerator bit per stage, both lanes share the divisor.
  logic                vld_s [1:M_W];
  logic [A_W-1:0]      d_s   [1:M_W];
  rcyl_pkg::rcyl_tag_t tag_s [1:M_W];
  logic [M_W-1:0]      ms    [1:M_W][LANES];
  logic [A_W-1:0]      rem_s [1:M_W][LANES];
  logic [Q_W-1:0]      q_s   [1:M_W][LANES];
  logic                sat_s [1:M_W][LANES];
  logic                neg_s [1:M_W][LANES];

  for (genvar k = 0; k < M_W; k++) begin : g_step
    // Quotient bits above the kept range only set the clamp flag.
    localparam bit HIGH_BIT = (k < M_W - Q_W);

    logic                vin;
    logic [A_W-1:0]      din;
    rcyl_pkg::rcyl_tag_t tin;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign din = divisor;
      assign tin = in_tag;
    end else begin : g_next
      assign vin = vld_s[k];
      assign din = d_s[k];
      assign tin = tag_s[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      d_s[k+1]   <= din;
      tag_s[k+1] <= tin;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [M_W-1:0] min;
      logic [A_W-1:0] rin;
      logic [Q_W-1:0] qin;
      logic           sin, nin;
      logic [A_W:0]   rsh;
      logic           ge;

      if (k == 0) begin : g_first
        assign min = num[l];
        assign rin = '0;
        assign qin = '0;
        assign sin = 1'b0;
        assign nin = num_neg[l];
      end else begin : g_next
        assign min = ms[k][l];
        assign rin = rem_s[k][l];
        assign qin = q_s[k][l];
        assign sin = sat_s[k][l];
        assign nin = neg_s[k][l];
      end

      assign rsh = {rin, min[M_W-1]};
      assign ge  = (rsh >= {1'b0, din});

      always_ff @(posedge clk) begin
        ms[k+1][l]    <= {min[M_W-2:0], 1'b0};
        rem_s[k+1][l] <= ge ? A_W'(rsh - {1'b0, din}) : rsh[A_W-1:0];
        q_s[k+1][l]   <= {qin[Q_W-2:0], ge};
        sat_s[k+1][l] <= sin | (ge & HIGH_BIT);
        neg_s[k+1][l] <= nin;
      end
    end
  end

  assign out_valid = vld_s[M_W];
  assign out_tag   = tag_s[M_W];

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quot[l]    = q_s[M_W][l];
    assign sat[l]     = sat_s[M_W][l];
    assign rem_nz[l]  = (rem_s[M_W][l] != '0);
    assign out_neg[l] = neg_s[M_W][l];
  end

endmodule

// ----- rtl/ray_cylinder_intersect.sv -----
// Ray against infinite cylinder with its axis parallel to y, Q16.16 fixed point.
// Input channel: drive the ray origin, direction, cylinder centre, radius and
// the best distance so far, and raise start for one cycle; the transfer takes
// place at a rising edge where start is high and busy is low. busy is high
// only while rst is high, so outside reset one transfer per cycle is taken.
// Result channel: done is high for exactly one cycle with hit and new_distance
// valid in that cycle; the receiver cannot hold a result back, so nothing
// stalls and no result waits.
// Path: 159 register stages in all from the transfer edge to done: 8 stages
// forming the discriminant, its wide squares from 32 by 32 partial products,
// 65 stages of square root (one root bit per stage), 2 stages forming the
// numerators, 82 stages of restoring division (one quotient bit per stage,
// both roots in parallel) and 2 stages of root selection.
// Throughput: one ray per clock cycle outside reset, results in transfer order.
// Reset: a synchronous rst drops every item in flight; no done follows for them.
module ray_cylinder_intersect (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rcyl_pkg::IN_W-1:0]    origin_x,
  input  logic signed [rcyl_pkg::IN_W-1:0]    origin_z,
  input  logic signed [rcyl_pkg::IN_W-1:0]    direction_x,
  input  logic signed [rcyl_pkg::IN_W-1:0]    direction_z,
  input  logic signed [rcyl_pkg::IN_W-1:0]    centre_x,
  input  logic signed [rcyl_pkg::IN_W-1:0]    centre_z,
  input  logic [rcyl_pkg::RAD_W-1:0]          radius,
  input  logic [rcyl_pkg::DIST_W-1:0]         best_distance,
  output logic                                done,
  output logic                                hit,
  output logic [rcyl_pkg::DIST_W-1:0]         new_distance
);

  localparam int DISC_W   = rcyl_pkg::DISC_W;
  localparam int ROOT_W   = rcyl_pkg::ROOT_W;
  localparam int H_W      = rcyl_pkg::H_W;
  localparam int N_W      = rcyl_pkg::N_W;
  localparam int M_W      = rcyl_pkg::M_W;
  localparam int A_W      = rcyl_pkg::A_W;
  localparam int Q_W      = rcyl_pkg::Q_W;
  localparam int T_W      = rcyl_pkg::T_W;
  localparam int DIST_W   = rcyl_pkg::DIST_W;
  localparam int SCALE_SH = rcyl_pkg::SCALE_SH;
  localparam int LANES    = rcyl_pkg::LANES;

  localparam logic signed [T_W-1:0] EPS  = T_W'(rcyl_pkg::EPS_LO);
  localparam logic signed [T_W-1:0] TMIN = T_W'(rcyl_pkg::T_MIN);
  localparam logic [T_W-1:0]        QSAT = T_W'(1) << Q_W;

  logic                    accept;
  logic                    q_valid;
  logic [DISC_W-1:0]       disc;
  rcyl_pkg::rcyl_side_t    q_side;
  logic                    s_valid;
  logic [ROOT_W-1:0]       s_root;
  rcyl_pkg::rcyl_side_t    s_side;

  logic                    n_valid;
  logic signed [N_W-1:0]   n1, n2;
  logic [A_W-1:0]          n_a, m_a;
  rcyl_pkg::rcyl_tag_t     n_tag, m_tag;
  logic signed [N_W-1:0]   hx, sx, mag1, mag2;

  logic                    m_valid;
  logic [M_W-1:0]          m_num [LANES];
  logic                    m_neg [LANES];

  logic                    d_valid;
  logic [Q_W-1:0]          d_quot [LANES];
  logic                    d_sat [LANES];
  logic                    d_rem_nz [LANES];
  logic                    d_neg [LANES];
  rcyl_pkg::rcyl_tag_t     d_tag;

  logic                    t_valid;
  logic signed [T_W-1:0]   t_root [LANES];
  rcyl_pkg::rcyl_tag_t     t_tag;
  logic signed [T_W-1:0]   best_x;
  logic                    take1, take2;

  assign busy   = rst;
  assign accept = start & ~busy;

  rcyl_quad u_quad (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .origin_x      (origin_x),
    .origin_z      (origin_z),
    .direction_x   (direction_x),
    .direction_z   (direction_z),
    .centre_x      (centre_x),
    .centre_z      (centre_z),
    .radius        (radius),
    .best_distance (best_distance),
    .out_valid     (q_valid),
    .disc          (disc),
    .out_side      (q_side)
  );

  rcyl_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .disc      (disc),
    .in_side   (q_side),
    .out_valid (s_valid),
    .root      (s_root),
    .out_side  (s_side)
  );

  // Numerators -h + s and -h - s.
  assign hx = $signed({{(N_W-H_W){s_side.h[H_W-1]}}, s_side.h});
  assign sx = $signed({{(N_W-ROOT_W){1'b0}}, s_root});

  always_ff @(posedge clk) begin
    n1          <= sx - hx;
    n2          <= -hx - sx;
    n_a         <= s_side.a;
    n_tag.best  <= s_side.best;
    n_tag.nohit <= s_side.nohit;
  end

  // Sign and scaled magnitude of each numerator.
  assign mag1 = n1[N_W-1] ? -n1 : n1;
  assign mag2 = n2[N_W-1] ? -n2 : n2;

  always_ff @(posedge clk) begin
    m_num[0] <= {mag1[M_W-SCALE_SH-1:0], {SCALE_SH{1'b0}}};
    m_num[1] <= {mag2[M_W-SCALE_SH-1:0], {SCALE_SH{1'b0}}};
    m_neg[0] <= n1[N_W-1];
    m_neg[1] <= n2[N_W-1];
    m_a      <= n_a;
    m_tag    <= n_tag;
  end

  // Valid bits around the numerator stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      n_valid <= s_valid;
      m_valid <= n_valid;
    end
  end

  rcyl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .num       (m_num),
    .num_neg   (m_neg),
    .divisor   (m_a),
    .in_tag    (m_tag),
    .out_valid (d_valid),
    .quot      (d_quot),
    .sat       (d_sat),
    .rem_nz    (d_rem_nz),
    .out_neg   (d_neg),
    .out_tag   (d_tag)
  );

  // Clamp the quotient magnitude and apply the sign, rounding toward minus infinity.
  for (genvar l = 0; l < LANES; l++) begin : g_root
    logic [T_W-1:0] mag;

    assign mag = d_sat[l] ? QSAT : T_W'(d_quot[l]);

    always_ff @(posedge clk) begin
      if (d_neg[l]) begin
        t_root[l] <= $signed(T_W'(0) - mag - T_W'(d_rem_nz[l]));
      end else begin
        t_root[l] <= $signed(mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    t_tag <= d_tag;
  end

  // Root selection: the smaller root, or the other one when the smaller is below EPS; equal roots give no hit.
  assign best_x = $signed(T_W'(t_tag.best));
  assign take1  = (t_root[0] < t_root[1] || t_root[1] < EPS) &&
                  t_root[0] > TMIN && t_root[0] < best_x;
  assign take2  = (t_root[1] < t_root[0] || t_root[0] < EPS) &&
                  t_root[1] > TMIN && t_root[1] < best_x;

  always_ff @(posedge clk) begin
    priority if (!t_tag.nohit && take1) begin
      hit          <= 1'b1;
      new_distance <= t_root[0][DIST_W-1:0];
    end else if (!t_tag.nohit && take2) begin
      hit          <= 1'b1;
      new_distance <= t_root[1][DIST_W-1:0];
    end else begin
      hit          <= 1'b0;
      new_distance <= t_tag.best;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      t_valid <= d_valid;
      done    <= t_valid;
    end
  end

endmodule
